// ===== sv/dvrt_pkg.sv =====
// Shared types, widths and operation codes for the distance-vector route table.
// Used by dvrt_entry_unit and distance_vector_route_table; depends on nothing.
package dvrt_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH   = 16;
  localparam int unsigned DEFAULT_INFINITE_COST = 999;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned COST_W  = 10;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned RCNT_W  = 5;

  typedef enum logic [2:0] {
    FUNC_CLEAR  = 3'd0,
    FUNC_APPEND = 3'd1,
    FUNC_APPLY  = 3'd2,
    FUNC_DEATH  = 3'd3,
    FUNC_READ   = 3'd4
  } func_e;

  typedef struct packed {
    logic [ID_W-1:0]   dest;
    logic [ID_W-1:0]   hop;
    logic [COST_W-1:0] cost;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Operands that the sequencer hands to the entry unit for one scan.
  typedef struct packed {
    logic              death;
    logic [ID_W-1:0]   node;
    logic [ID_W-1:0]   rdest;
    logic [ID_W-1:0]   sender;
    logic              rhop_me;
    logic [COST_W-1:0] cost;
  } scan_ctrl_t;

endpackage

// ===== sv/dvrt_entry_unit.sv =====
// Shared compare and update unit applied to one stored route per cycle.
// Depends on dvrt_pkg.
module dvrt_entry_unit #(
  parameter int unsigned INFINITE_COST = dvrt_pkg::DEFAULT_INFINITE_COST
) (
  input  dvrt_pkg::entry_t     entry_i,
  input  dvrt_pkg::scan_ctrl_t ctrl_i,
  output dvrt_pkg::entry_t     entry_o,
  output logic                 wr_o,
  output logic                 match_o
);
  import dvrt_pkg::*;

  localparam logic [COST_W-1:0] Inf = COST_W'(INFINITE_COST);

  always_comb begin
    entry_o = entry_i;
    wr_o    = 1'b0;
    match_o = 1'b0;
    if (ctrl_i.death) begin
      if (entry_i.hop == ctrl_i.node && entry_i.cost != Inf) begin
        entry_o.cost = Inf;
        wr_o         = 1'b1;
      end
    end else if (entry_i.dest == ctrl_i.rdest) begin
      match_o = 1'b1;
      if (entry_i.hop == ctrl_i.sender) begin
        // The sender is our next hop: its word is taken as it stands.
        if (entry_i.cost != ctrl_i.cost) begin
          entry_o.cost = ctrl_i.cost;
          wr_o         = 1'b1;
        end
      end else if (!ctrl_i.rhop_me && entry_i.cost > ctrl_i.cost) begin
        entry_o.cost = ctrl_i.cost;
        entry_o.hop  = ctrl_i.sender;
        wr_o         = 1'b1;
      end
    end
  end

endmodule

// ===== sv/distance_vector_route_table.sv =====
// Distance-vector route table, top level. Depends on dvrt_pkg and dvrt_entry_unit.
// A transaction goes from idle to the finish state, which registers its result once
// the output is free. A read passes the read state on the way; a scan over a non-empty
// table passes the scan state, once per route, then the drain state, reading the table
// memory through its single read port. Input is taken only in idle, one at a time.
// Reset (asynchronous, active low) empties the table and sets my_id to 0; no clearing pass.
module distance_vector_route_table #(
  parameter int unsigned TABLE_DEPTH   = dvrt_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned INFINITE_COST = dvrt_pkg::DEFAULT_INFINITE_COST
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: my_id is written whenever cfg_we_i is high.
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // Input transactions.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: node_id[7:0], entry_index[11:8], origin_id[19:12],
  // packet_dest[27:20], route_dest[35:28], route_next_hop[43:36],
  // route_cost[53:44], link_cost[63:54]
  input  logic [63:0] s_axis_tdata,
  // tuser: func[2:0]
  input  logic [2:0]  s_axis_tuser,
  // Result transactions.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: entry_dest[7:0], entry_next_hop[15:8], entry_cost[25:16],
  // route_count[30:26], zero[31]
  output logic [31:0] m_axis_tdata,
  // tuser from bit 0: changed[0], table_full[1], entry_valid[2]
  output logic [2:0]  m_axis_tuser
);
  import dvrt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RD_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [COST_W-1:0] Inf = COST_W'(INFINITE_COST);

  // The sequencer. A scan issues one memory read per cycle; the entry unit sees the
  // registered data in the next cycle, so the last route is handled in the drain state.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_READ,
    ST_FINISH
  } state_e;

  state_e state_q;

  logic [ID_W-1:0]    my_id_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   ptr_q;
  logic [CNT_W-1:0]   wptr_q;
  logic               vld_q;
  logic               found_q;
  logic               chg_q;

  // Operands of the transaction in progress.
  logic [2:0]         func_q;
  logic [ID_W-1:0]    node_q;
  logic [INDEX_W-1:0] idx_q;
  logic [ID_W-1:0]    sender_q;
  logic [ID_W-1:0]    rdest_q;
  logic [COST_W-1:0]  rcost_q;
  logic [COST_W-1:0]  cost_q;
  logic               rhop_me_q;
  logic               addr_me_q;
  logic               in_range_q;

  logic               out_valid_q;
  logic [2:0]         out_user_q;
  logic [31:0]        out_data_q;

  // Table memory, one route to a word, with a registered read port.
  logic [ENTRY_W-1:0] mem_q [TABLE_DEPTH];
  entry_t             rd_q;

  // Unpacked input fields.
  logic [ID_W-1:0]    in_node;
  logic [INDEX_W-1:0] in_idx;
  logic [ID_W-1:0]    in_sender;
  logic [ID_W-1:0]    in_pdest;
  logic [ID_W-1:0]    in_rdest;
  logic [ID_W-1:0]    in_rhop;
  logic [COST_W-1:0]  in_rcost;
  logic [COST_W-1:0]  in_lcost;
  logic [COST_W:0]    in_sum;
  logic [COST_W-1:0]  in_cost;

  assign in_node   = s_axis_tdata[7:0];
  assign in_idx    = s_axis_tdata[11:8];
  assign in_sender = s_axis_tdata[19:12];
  assign in_pdest  = s_axis_tdata[27:20];
  assign in_rdest  = s_axis_tdata[35:28];
  assign in_rhop   = s_axis_tdata[43:36];
  assign in_rcost  = s_axis_tdata[53:44];
  assign in_lcost  = s_axis_tdata[63:54];

  // The received cost is saturated at infinity before it is held.
  assign in_sum  = {1'b0, in_rcost} + {1'b0, in_lcost};
  assign in_cost = (in_sum > {1'b0, Inf}) ? Inf : in_sum[COST_W-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = out_data_q;

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Shared entry unit.
  scan_ctrl_t scan_ctrl;
  entry_t     unit_entry;
  logic       unit_wr;
  logic       unit_match;

  always_comb begin
    scan_ctrl.death   = (func_q == FUNC_DEATH);
    scan_ctrl.node    = node_q;
    scan_ctrl.rdest   = rdest_q;
    scan_ctrl.sender  = sender_q;
    scan_ctrl.rhop_me = rhop_me_q;
    scan_ctrl.cost    = cost_q;
  end

  dvrt_entry_unit #(
    .INFINITE_COST(INFINITE_COST)
  ) u_entry (
    .entry_i (rd_q),
    .ctrl_i  (scan_ctrl),
    .entry_o (unit_entry),
    .wr_o    (unit_wr),
    .match_o (unit_match)
  );

  // Completion of a transaction, the append and the memory ports.
  logic               fin_go;
  logic               room;
  logic               want_app;
  logic               app_go;
  logic               scan_wr;
  entry_t             app_entry;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   ptr_nxt;
  logic [CNT_W-1:0]   count_nxt;
  logic               res_changed;
  logic               res_full;
  entry_t             res_entry;

  always_comb begin
    fin_go   = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);
    room     = (count_q < CNT_W'(TABLE_DEPTH));
    want_app = (func_q == FUNC_APPEND) ||
               ((func_q == FUNC_APPLY) && addr_me_q && !found_q);
    app_go   = fin_go && want_app && room;
    scan_wr  = vld_q && unit_wr;
    ptr_nxt  = ptr_q + CNT_W'(1);

    if (func_q == FUNC_APPEND) begin
      app_entry.dest = node_q;
      app_entry.hop  = node_q;
      app_entry.cost = rcost_q;
    end else begin
      app_entry.dest = rdest_q;
      app_entry.hop  = sender_q;
      app_entry.cost = cost_q;
    end

    mem_we    = scan_wr || app_go;
    mem_waddr = scan_wr ? wptr_q[IDX_W-1:0] : count_q[IDX_W-1:0];
    mem_wdata = scan_wr ? unit_entry : app_entry;

    rd_en   = (state_q == ST_SCAN) || (state_q == ST_READ);
    rd_addr = (state_q == ST_READ) ? IDX_W'(idx_q) : ptr_q[IDX_W-1:0];

    // Outcome of the transaction, taken when it completes.
    res_changed = 1'b0;
    res_full    = 1'b0;
    res_entry   = '0;
    count_nxt   = count_q;
    case (func_q)
      FUNC_CLEAR: begin
        res_changed = (count_q != '0);
        count_nxt   = '0;
      end
      FUNC_APPEND: begin
        res_changed = room;
        res_full    = !room;
      end
      FUNC_APPLY: begin
        if (addr_me_q) begin
          if (found_q) begin
            res_changed = chg_q;
          end else begin
            res_changed = room;
            res_full    = !room;
          end
        end
      end
      FUNC_DEATH: begin
        res_changed = chg_q;
      end
      FUNC_READ: begin
        if (in_range_q) begin
          res_entry = rd_q;
        end
      end
      default: begin
      end
    endcase
    if (want_app && room) begin
      count_nxt = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= entry_t'(mem_q[rd_addr]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_id_q <= '0;
    end else if (cfg_we_i) begin
      my_id_q <= cfg_wdata_i;
    end
  end

  // Operands are captured with each accepted transaction; they need no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q     <= s_axis_tuser;
      node_q     <= in_node;
      idx_q      <= in_idx;
      sender_q   <= in_sender;
      rdest_q    <= in_rdest;
      rcost_q    <= in_rcost;
      cost_q     <= in_cost;
      rhop_me_q  <= (in_rhop == my_id_q);
      addr_me_q  <= (in_pdest == my_id_q);
      in_range_q <= (RD_W'(in_idx) < RD_W'(count_q));
    end
  end

  // Sequencer with the route count and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ptr_q       <= '0;
      wptr_q      <= '0;
      vld_q       <= 1'b0;
      found_q     <= 1'b0;
      chg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_user_q  <= '0;
      out_data_q  <= '0;
    end else begin
      // A result taken in the same cycle as a new one is loaded leaves valid high.
      if (out_valid_q && m_axis_tready && !fin_go) begin
        out_valid_q <= 1'b0;
      end

      if (vld_q) begin
        found_q <= found_q || unit_match;
        chg_q   <= chg_q || unit_wr;
      end

      case (state_q)
        ST_IDLE: begin
          vld_q <= 1'b0;
          if (in_fire) begin
            ptr_q   <= '0;
            found_q <= 1'b0;
            chg_q   <= 1'b0;
            if (((s_axis_tuser == FUNC_APPLY && in_pdest == my_id_q) ||
                 s_axis_tuser == FUNC_DEATH) && count_q != '0) begin
              state_q <= ST_SCAN;
            end else if (s_axis_tuser == FUNC_READ) begin
              state_q <= ST_READ;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_SCAN: begin
          vld_q  <= 1'b1;
          wptr_q <= ptr_q;
          if (ptr_nxt == count_q) begin
            state_q <= ST_DRAIN;
          end else begin
            ptr_q <= ptr_nxt;
          end
        end
        ST_DRAIN: begin
          vld_q   <= 1'b0;
          state_q <= ST_FINISH;
        end
        ST_READ: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (fin_go) begin
            count_q     <= count_nxt;
            out_valid_q <= 1'b1;
            out_user_q  <= {(func_q == FUNC_READ) && in_range_q, res_full, res_changed};
            out_data_q  <= {1'b0, RCNT_W'(count_nxt), res_entry.cost,
                            res_entry.hop, res_entry.dest};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The route count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("route count beyond table depth");

  // A dropped append never reports a change to the table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("changed and table_full both set");

  // The route count moves only when a transaction completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_FINISH) |=> $stable(count_q))
    else $error("route count changed outside completion");

  // Scan writes fall only in the scan and drain states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_wr |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("table write outside a scan");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the distance-vector route table (distance_vector_route_table).
// It holds its own model of the table and checks every result transaction against it.
// Depends on dvrt_pkg and the RTL of the block; it reads no files.
`timescale 1ns / 100ps

module tb;
  import dvrt_pkg::*;

  // The block is built with its default sizes, so the model uses the same ones.
  localparam int unsigned ROUTE_SLOTS = DEFAULT_TABLE_DEPTH;
  localparam int unsigned INF_COST    = DEFAULT_INFINITE_COST;
  localparam int unsigned SLOT_W      = $clog2(ROUTE_SLOTS);

  // Codes 5 to 7 carry no operation; the block only reports the route count for them.
  localparam logic [2:0] FUNC_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_LAST  = 3'd7;

  // A handshake stalled for this many cycles in a row means the block has hung.
  localparam int unsigned STALL_LIMIT = 2000;
  // Settling time after the last result.
  localparam int unsigned SETTLE_CYCLES = 30;

  // One operation as it travels on the input stream.
  typedef struct packed {
    logic [2:0]        func;
    logic [ID_W-1:0]   node;
    logic [INDEX_W-1:0] idx;
    logic [ID_W-1:0]   sender;
    logic [ID_W-1:0]   pdest;
    logic [ID_W-1:0]   rdest;
    logic [ID_W-1:0]   rhop;
    logic [COST_W-1:0] rcost;
    logic [COST_W-1:0] lcost;
  } route_op_t;

  // One result as it travels on the output stream.
  typedef struct packed {
    logic              changed;
    logic              full;
    logic              valid;
    logic [ID_W-1:0]   dest;
    logic [ID_W-1:0]   hop;
    logic [COST_W-1:0] cost;
    logic [RCNT_W-1:0] count;
  } route_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  // Our own copy of the routing table and of the router identifier.
  logic [ID_W-1:0]   rt_dest [ROUTE_SLOTS];
  logic [ID_W-1:0]   rt_hop  [ROUTE_SLOTS];
  logic [COST_W-1:0] rt_cost [ROUTE_SLOTS];
  int unsigned       rt_count  = 0;
  logic [ID_W-1:0]   router_id = '0;

  // Results predicted for accepted transactions, oldest first.
  route_result_t route_expect_q[$];
  int unsigned   mismatches = 0;

  // Handshake pacing. Each side draws its wait per transaction from 0 to its maximum;
  // a non-zero hold request makes the receiver stall once for that many cycles.
  int unsigned tx_gap_max  = 16;
  int unsigned rx_gap_max  = 16;
  int unsigned rx_hold_req = 0;

  // Neighbours and destinations used by one phase of random traffic.
  logic [ID_W-1:0] peers [6];

  distance_vector_route_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one operation to the model table and returns the result it should produce.
  function automatic route_result_t predict_route_op(route_op_t op);
    route_result_t res;
    int unsigned   new_cost;
    bit            found;
    int unsigned   j;
    res = '0;
    case (op.func)
      FUNC_CLEAR: begin
        res.changed = (rt_count != 0);
        rt_count = 0;
      end
      FUNC_APPEND: begin
        // A direct route: the neighbour is destination and next hop, the cost unsaturated.
        if (rt_count < ROUTE_SLOTS) begin
          rt_dest[rt_count[SLOT_W-1:0]] = op.node;
          rt_hop[rt_count[SLOT_W-1:0]]  = op.node;
          rt_cost[rt_count[SLOT_W-1:0]] = op.rcost;
          rt_count++;
          res.changed = 1'b1;
        end else begin
          res.full = 1'b1;
        end
      end
      FUNC_APPLY: begin
        // Packets for another router are dropped without touching the table.
        if (op.pdest == router_id) begin
          new_cost = op.rcost + op.lcost;
          if (new_cost > INF_COST) new_cost = INF_COST;
          found = 1'b0;
          // Every entry for the destination is considered, duplicates included.
          for (j = 0; j < rt_count; j++) begin
            if (rt_dest[j[SLOT_W-1:0]] == op.rdest) begin
              found = 1'b1;
              if (rt_hop[j[SLOT_W-1:0]] == op.sender) begin
                // The current next hop speaks: its word is taken even if worse.
                if (rt_cost[j[SLOT_W-1:0]] != new_cost) begin
                  rt_cost[j[SLOT_W-1:0]] = new_cost[COST_W-1:0];
                  res.changed = 1'b1;
                end
              end else if (op.rhop != router_id && rt_cost[j[SLOT_W-1:0]] > new_cost) begin
                // A cheaper route, unless the sender routes back through us.
                rt_cost[j[SLOT_W-1:0]] = new_cost[COST_W-1:0];
                rt_hop[j[SLOT_W-1:0]]  = op.sender;
                res.changed = 1'b1;
              end
            end
          end
          if (!found) begin
            if (rt_count < ROUTE_SLOTS) begin
              rt_dest[rt_count[SLOT_W-1:0]] = op.rdest;
              rt_hop[rt_count[SLOT_W-1:0]]  = op.sender;
              rt_cost[rt_count[SLOT_W-1:0]] = new_cost[COST_W-1:0];
              rt_count++;
              res.changed = 1'b1;
            end else begin
              res.full = 1'b1;
            end
          end
        end
      end
      FUNC_DEATH: begin
        for (j = 0; j < rt_count; j++) begin
          if (rt_hop[j[SLOT_W-1:0]] == op.node && rt_cost[j[SLOT_W-1:0]] != INF_COST) begin
            rt_cost[j[SLOT_W-1:0]] = COST_W'(INF_COST);
            res.changed = 1'b1;
          end
        end
      end
      FUNC_READ: begin
        if (op.idx < rt_count) begin
          res.valid = 1'b1;
          res.dest  = rt_dest[op.idx];
          res.hop   = rt_hop[op.idx];
          res.cost  = rt_cost[op.idx];
        end
      end
      default: ;
    endcase
    res.count = rt_count[RCNT_W-1:0];
    return res;
  endfunction

  // Every field random, so that bits the operation ignores still toggle.
  function automatic route_op_t random_op();
    route_op_t op;
    op.func   = 3'($urandom_range(0, 7));
    op.node   = ID_W'($urandom_range(0, 255));
    op.idx    = INDEX_W'($urandom_range(0, 15));
    op.sender = ID_W'($urandom_range(0, 255));
    op.pdest  = ID_W'($urandom_range(0, 255));
    op.rdest  = ID_W'($urandom_range(0, 255));
    op.rhop   = ID_W'($urandom_range(0, 255));
    op.rcost  = COST_W'($urandom_range(0, 1023));
    op.lcost  = COST_W'($urandom_range(0, 1023));
    return op;
  endfunction

  // Mostly well-formed updates among a small set of peers, so that destinations
  // match and forced updates, better routes and split horizon all come up; the
  // rest is appends, deaths, reads, the odd clear and some noise.
  function automatic route_op_t traffic_op();
    route_op_t   op;
    int unsigned pick;
    op   = random_op();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      op.func   = FUNC_APPLY;
      op.pdest  = router_id;
      op.rdest  = peers[3'($urandom_range(0, 5))];
      op.sender = peers[3'($urandom_range(0, 5))];
      if ($urandom_range(0, 3) == 0) op.rhop = router_id;
      else if ($urandom_range(0, 1) == 0) op.rhop = peers[3'($urandom_range(0, 5))];
      if ($urandom_range(0, 2) != 0) op.rcost = COST_W'($urandom_range(0, 60));
      if ($urandom_range(0, 2) != 0) op.lcost = COST_W'($urandom_range(0, 60));
    end else if (pick < 69) begin
      op.func = FUNC_APPEND;
      op.node = peers[3'($urandom_range(0, 5))];
    end else if (pick < 76) begin
      op.func = FUNC_DEATH;
      if ($urandom_range(0, 3) != 0) op.node = peers[3'($urandom_range(0, 5))];
    end else if (pick < 88) begin
      op.func = FUNC_READ;
    end else if (pick < 90) begin
      op.func = FUNC_CLEAR;
    end else if (pick < 96) begin
      // Updates addressed elsewhere, or for destinations nobody knows.
      op.func = FUNC_APPLY;
    end else if (pick < 98) begin
      op.func = 3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST));
    end
    return op;
  endfunction

  // Offers one transaction and, once accepted, records the result it should give.
  // The valid is left high on return so that a following transaction can go
  // back to back; anything that needs the input idle lowers it first.
  task automatic send_route_op(input route_op_t op);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {op.lcost, op.rcost, op.rhop, op.rdest, op.pdest, op.sender,
                      op.idx, op.node};
    s_axis_tuser  <= op.func;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    route_expect_q.push_back(predict_route_op(op));
  endtask

  // Lowers the input valid and waits until every outstanding result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (route_expect_q.size() != 0);
  endtask

  // The register is only written with the block idle.
  task automatic set_router_id(input logic [ID_W-1:0] id);
    drain_results();
    cfg_wdata_i <= id;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    router_id = id;
  endtask

  task automatic send_apply(input logic [ID_W-1:0] pdest, input logic [ID_W-1:0] rdest,
                            input logic [ID_W-1:0] sender, input logic [ID_W-1:0] rhop,
                            input logic [COST_W-1:0] rcost,
                            input logic [COST_W-1:0] lcost);
    route_op_t op;
    op        = random_op();
    op.func   = FUNC_APPLY;
    op.pdest  = pdest;
    op.rdest  = rdest;
    op.sender = sender;
    op.rhop   = rhop;
    op.rcost  = rcost;
    op.lcost  = lcost;
    send_route_op(op);
  endtask

  task automatic send_simple(input logic [2:0] func, input logic [ID_W-1:0] node,
                             input logic [INDEX_W-1:0] idx,
                             input logic [COST_W-1:0] rcost);
    route_op_t op;
    op       = random_op();
    op.func  = func;
    op.node  = node;
    op.idx   = idx;
    op.rcost = rcost;
    send_route_op(op);
  endtask

  // Straight after reset: a read of an empty table, a clear with nothing to clear,
  // a death with nothing to kill and the codes that carry no operation.
  task automatic test_empty_table();
    send_simple(FUNC_READ, 8'h00, 4'd15, '0);
    send_simple(FUNC_CLEAR, 8'h00, 4'd0, '0);
    send_simple(FUNC_DEATH, 8'h00, 4'd0, '0);
    send_simple(FUNC_UNUSED_FIRST, 8'h00, 4'd0, '0);
    send_simple(FUNC_UNUSED_LAST, 8'hFF, 4'd15, '1);
  endtask

  // Fills every slot with direct routes, including the extreme identifiers, a cost
  // above infinity that must be kept as given and pairs of duplicate destinations,
  // then tries one more append, which must be refused as full.
  task automatic test_fill_table();
    int unsigned k;
    for (k = 0; k < ROUTE_SLOTS; k++) begin
      if (k == 0) send_simple(FUNC_APPEND, 8'h00, 4'd0, 10'd0);
      else if (k == 1) send_simple(FUNC_APPEND, 8'hFF, 4'd0, 10'd1023);
      else send_simple(FUNC_APPEND, 8'(8'h20 + k / 2), 4'd0, 10'(50 + 40 * k));
    end
    send_simple(FUNC_APPEND, 8'h77, 4'd0, 10'd5);
  endtask

  // The update rules, run against the full table left by test_fill_table with
  // the router identifier at its upper extreme.
  task automatic test_apply_rules();
    // Not addressed to this router: ignored.
    send_apply(8'hFE, 8'h21, 8'h21, 8'h00, 10'd0, 10'd0);
    // Unknown destination while full: the append is refused.
    send_apply(router_id, 8'h99, 8'h21, 8'h00, 10'd1, 10'd1);
    // Forced update of both duplicate entries through 0x21, then the same cost again.
    send_apply(router_id, 8'h21, 8'h21, 8'h00, 10'd60, 10'd20);
    send_apply(router_id, 8'h21, 8'h21, 8'h00, 10'd60, 10'd20);
    // Cheaper route whose sender goes through us: split horizon blocks it.
    send_apply(router_id, 8'h22, 8'h05, router_id, 10'd1, 10'd1);
    // The same route with another next hop is taken, and 0x05 becomes the hop.
    send_apply(router_id, 8'h22, 8'h05, 8'h06, 10'd1, 10'd1);
    // Largest costs from the current next hop saturate at infinity.
    send_apply(router_id, 8'hFF, 8'hFF, 8'h00, 10'd1023, 10'd1023);
    // Neighbour 0x05 dies; the second death finds nothing left to change.
    send_simple(FUNC_DEATH, 8'h05, 4'd0, '0);
    send_simple(FUNC_DEATH, 8'h05, 4'd0, '0);
    send_simple(FUNC_READ, 8'h00, 4'd3, '0);
    send_simple(FUNC_READ, 8'h00, 4'd15, '0);
    send_simple(FUNC_CLEAR, 8'h00, 4'd0, '0);
    // Unknown destination into an empty table is appended.
    send_apply(router_id, 8'h99, 8'h21, 8'h00, 10'd7, 10'd9);
  endtask

  task automatic test_random_traffic(input logic [ID_W-1:0] id, input int unsigned n);
    int unsigned k;
    set_router_id(id);
    for (k = 0; k < 6; k++) peers[k[2:0]] = ID_W'($urandom_range(0, 255));
    for (k = 0; k < n; k++) send_route_op(traffic_op());
  endtask

  // The receiver stops for a long stretch while the sender keeps offering, so the
  // block has to hold its result and refuse further input.
  task automatic test_output_backpressure();
    int unsigned k;
    tx_gap_max  = 0;
    rx_hold_req = 400;
    for (k = 0; k < 40; k++) send_route_op(traffic_op());
    tx_gap_max  = 16;
  endtask

  // The sender stops until the block has returned everything, then carries on.
  task automatic test_sender_pause();
    int unsigned k;
    for (k = 0; k < 20; k++) send_route_op(traffic_op());
    drain_results();
    for (k = 0; k < 20; k++) send_route_op(traffic_op());
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: a random stall before each transaction, or a long one on request.
  initial begin
    int unsigned stall;
    forever begin
      if (rx_hold_req != 0) begin
        stall = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        stall = $urandom_range(0, rx_gap_max);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Each result transaction is held against the oldest prediction, field by field.
  always @(posedge clk_i) begin
    route_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (route_expect_q.size() == 0) begin
        $error("result transaction with no operation outstanding");
        mismatches++;
      end else begin
        want = route_expect_q.pop_front();
        check_field("changed", 32'(want.changed), 32'(m_axis_tuser[0]));
        check_field("table_full", 32'(want.full), 32'(m_axis_tuser[1]));
        check_field("entry_valid", 32'(want.valid), 32'(m_axis_tuser[2]));
        check_field("entry_dest", 32'(want.dest), 32'(m_axis_tdata[7:0]));
        check_field("entry_next_hop", 32'(want.hop), 32'(m_axis_tdata[15:8]));
        check_field("entry_cost", 32'(want.cost), 32'(m_axis_tdata[25:16]));
        check_field("route_count", 32'(want.count), 32'(m_axis_tdata[30:26]));
        check_field("padding", 0, 32'(m_axis_tdata[31]));
      end
    end
  end

  // Watchdog: too long without any transaction on either side ends the run.
  always @(posedge clk_i) begin
    int unsigned quiet_cycles;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    set_router_id(8'hFF);
    test_fill_table();
    test_apply_rules();
    test_random_traffic(8'h00, 130);
    test_random_traffic(8'($urandom_range(0, 255)), 130);

    // A stretch with neither side idling.
    tx_gap_max = 0;
    rx_gap_max = 0;
    test_random_traffic(8'($urandom_range(0, 255)), 80);
    tx_gap_max = 16;
    rx_gap_max = 16;

    test_output_backpressure();
    test_sender_pause();
    test_random_traffic(8'hFF, 130);
    test_random_traffic(8'($urandom_range(0, 255)), 150);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && route_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
